/* sv/ira_pkg.sv */
// ----------------------------------------------------------------------------
// ira_pkg
// Shared constants and codes for the id recycling allocator.
// ----------------------------------------------------------------------------
package ira_pkg;

  // number of ids the allocator can hand out
  localparam int MAX_IDS = 24;

  // payload field widths
  localparam int TYPE_W   = 2;
  localparam int ID_W     = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // internal widths: list address and counters that can hold MAX_IDS
  localparam int AW    = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam int CNT_W = $clog2(MAX_IDS + 1);

  // request types
  localparam logic [TYPE_W-1:0] REQ_CREATE = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_SELECT = 2'd2;
  localparam logic [TYPE_W-1:0] REQ_LOOKUP = 2'd3;

  // response status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

endpackage

/* sv/ira_if.sv */
// ----------------------------------------------------------------------------
// ira_if
// Request and response channels of the id recycling allocator.
// ----------------------------------------------------------------------------
interface ira_req_if import ira_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] req_type;
  logic [ID_W-1:0]   req_id;

  modport source (output valid, output req_type, output req_id, input ready);
  modport sink   (input valid, input req_type, input req_id, output ready);
endinterface

interface ira_rsp_if import ira_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     result_id;
  logic [COUNT_W-1:0]  live_count;
  logic                selected_valid;
  logic [ID_W-1:0]     selected_id;

  modport source (output valid, output status, output result_id, output live_count,
                  output selected_valid, output selected_id, input ready);
  modport sink   (input valid, input status, input result_id, input live_count,
                  input selected_valid, input selected_id, output ready);
endinterface

/* sv/ira_ram.sv */
// ----------------------------------------------------------------------------
// ira_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ira_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* sv/id_recycling_allocator_unit.sv */
// ----------------------------------------------------------------------------
// id_recycling_allocator_unit
// Hands out small ids, takes them back and tracks one selected id.
// ----------------------------------------------------------------------------
// One request is in work at a time and each gives exactly one response item.
// A create goes straight to loading its response when no freed id waits or
// the table is full; when it recycles a freed id it first reads the free
// stack twice, then writes back once. Remove, select and lookup scan the
// live list in its RAM, one entry per cycle through the registered read
// port, and a remove that hits then moves the last live entry into the
// freed slot. A new request is taken once the previous response is loaded
// into the output register, even while that response still waits to be
// taken. Both lists sit in RAMs that need no clearing: only entries below
// the live and free counts are ever used.
// ----------------------------------------------------------------------------
module id_recycling_allocator_unit import ira_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  ira_req_if.sink    req,
  ira_rsp_if.source  rsp
);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;  // waiting for a request
  localparam logic [2:0] S_SCAN   = 3'd1;  // walking the live list
  localparam logic [2:0] S_RM_WR  = 3'd2;  // compact live list, push free id
  localparam logic [2:0] S_CR_RDL = 3'd3;  // free[0] arrives, read last free
  localparam logic [2:0] S_CR_WR  = 3'd4;  // move last free into slot 0
  localparam logic [2:0] S_RESP   = 3'd5;  // load response register

  logic [2:0]          state;
  logic [TYPE_W-1:0]   req_type_q;
  logic [ID_W-1:0]     req_id_q;
  logic [CNT_W-1:0]    live_total;
  logic [CNT_W-1:0]    free_count;
  logic                sel_valid;
  logic [ID_W-1:0]     sel_id;
  logic [CNT_W-1:0]    scan_addr;   // next live entry to read
  logic                chk_valid;   // read data belongs to a scanned entry
  logic [AW-1:0]       chk_pos;     // entry whose data is on the read port
  logic [AW-1:0]       hit_pos;
  logic [ID_W-1:0]     new_id;
  logic [STATUS_W-1:0] res_status;
  logic [ID_W-1:0]     res_id;

  // live list RAM ports
  logic            live_we;
  logic [AW-1:0]   live_wa;
  logic [ID_W-1:0] live_wd;
  logic [AW-1:0]   live_ra;
  logic [ID_W-1:0] live_rd;

  // free stack RAM ports
  logic            free_we;
  logic [AW-1:0]   free_wa;
  logic [ID_W-1:0] free_wd;
  logic [AW-1:0]   free_ra;
  logic [ID_W-1:0] free_rd;

  logic          accept;
  logic          hit;
  logic          miss;
  logic          is_full;
  logic [AW-1:0] last_live;
  logic          rsp_load;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign is_full   = (live_total >= CNT_W'(MAX_IDS));
  assign last_live = AW'(live_total - CNT_W'(1));

  // output register free or being emptied this cycle
  assign rsp_load  = (state == S_RESP) && (!rsp.valid || rsp.ready);

  // scan outcome: data of the previous read compared against the request
  assign hit  = (state == S_SCAN) && chk_valid && (live_rd == req_id_q);
  assign miss = (state == S_SCAN) && !hit && (scan_addr == live_total);

  ira_ram #(.WIDTH(ID_W), .DEPTH(MAX_IDS)) u_live_ram (
    .clk     (clk),
    .wr_en   (live_we),
    .wr_addr (live_wa),
    .wr_data (live_wd),
    .rd_addr (live_ra),
    .rd_data (live_rd)
  );

  ira_ram #(.WIDTH(ID_W), .DEPTH(MAX_IDS)) u_free_ram (
    .clk     (clk),
    .wr_en   (free_we),
    .wr_addr (free_wa),
    .wr_data (free_wd),
    .rd_addr (free_ra),
    .rd_data (free_rd)
  );

  // memory address and write control
  always_comb begin
    // scan reads one entry per cycle; a remove hit fetches the last entry
    live_ra = scan_addr[AW-1:0];
    if (hit && (req_type_q == REQ_REMOVE)) begin
      live_ra = last_live;
    end

    // free[0] is read while idle, the top of the stack in S_CR_RDL
    free_ra = '0;
    if (state == S_CR_RDL) begin
      free_ra = AW'(free_count - CNT_W'(1));
    end

    live_we = 1'b0;
    live_wa = AW'(live_total);
    live_wd = ID_W'(live_total);
    free_we = 1'b0;
    free_wa = AW'(free_count);
    free_wd = req_id_q;

    unique case (state)
      S_IDLE: begin
        // fresh id: append the current count
        if (accept && (req.req_type == REQ_CREATE) && !is_full &&
            (free_count == '0)) begin
          live_we = 1'b1;
        end
      end
      S_RM_WR: begin
        // last live entry fills the freed slot
        live_we = 1'b1;
        live_wa = hit_pos;
        live_wd = live_rd;
        free_we = (free_count < CNT_W'(MAX_IDS));
      end
      S_CR_WR: begin
        // recycled id appended, last free entry moves into slot 0
        live_we = 1'b1;
        live_wd = new_id;
        free_we = 1'b1;
        free_wa = '0;
        free_wd = free_rd;
      end
      default: begin
      end
    endcase
  end

  // sequencer and bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      live_total <= '0;
      free_count <= '0;
      sel_valid  <= 1'b0;
      sel_id     <= '0;
      chk_valid  <= 1'b0;
      rsp.valid  <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req_type_q <= req.req_type;
            req_id_q   <= req.req_id;
            scan_addr  <= '0;
            chk_valid  <= 1'b0;
            if (req.req_type == REQ_CREATE) begin
              if (is_full) begin
                res_status <= ST_FULL;
                res_id     <= '0;
                state      <= S_RESP;
              end else if (free_count == '0) begin
                res_status <= ST_OK;
                res_id     <= ID_W'(live_total);
                live_total <= live_total + CNT_W'(1);
                state      <= S_RESP;
              end else begin
                state <= S_CR_RDL;
              end
            end else begin
              state <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          if (hit) begin
            hit_pos    <= chk_pos;
            res_status <= ST_OK;
            res_id     <= req_id_q;
            if (req_type_q == REQ_REMOVE) begin
              state <= S_RM_WR;
            end else begin
              if (req_type_q == REQ_SELECT) begin
                sel_valid <= 1'b1;
                sel_id    <= req_id_q;
              end
              state <= S_RESP;
            end
          end else if (miss) begin
            res_status <= ST_ABSENT;
            res_id     <= req_id_q;
            state      <= S_RESP;
          end else begin
            chk_valid <= 1'b1;
            chk_pos   <= scan_addr[AW-1:0];
            scan_addr <= scan_addr + CNT_W'(1);
          end
        end

        S_RM_WR: begin
          // dropping the selected id clears the selection
          if (sel_valid && (sel_id == req_id_q)) begin
            sel_valid <= 1'b0;
            sel_id    <= '0;
          end
          if (free_count < CNT_W'(MAX_IDS)) begin
            free_count <= free_count + CNT_W'(1);
          end
          live_total <= live_total - CNT_W'(1);
          state      <= S_RESP;
        end

        S_CR_RDL: begin
          new_id <= free_rd;
          state  <= S_CR_WR;
        end

        S_CR_WR: begin
          free_count <= free_count - CNT_W'(1);
          live_total <= live_total + CNT_W'(1);
          res_status <= ST_OK;
          res_id     <= new_id;
          state      <= S_RESP;
        end

        S_RESP: begin
          if (rsp_load) begin
            rsp.status         <= res_status;
            rsp.result_id      <= res_id;
            rsp.live_count     <= COUNT_W'(live_total);
            rsp.selected_valid <= sel_valid;
            rsp.selected_id    <= sel_valid ? sel_id : '0;
            state              <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
